// ----- rtl/skf_pkg.sv -----
package skf_pkg;

  localparam int EST_W      = 32;
  localparam int VAR_W      = 32;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_PROCESS_NOISE = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_MEAS_NOISE    = 1'b1;

  localparam logic signed [EST_W-1:0] EST_MAX_S = {1'b0, {(EST_W-1){1'b1}}};
  localparam logic signed [EST_W-1:0] EST_MIN_S = {1'b1, {(EST_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MUL_INIT,
    ST_MUL,
    ST_FINISH
  } skf_state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic mul_init;
    logic mul_step;
    logic finish;
  } skf_cmd_t;

  typedef struct packed {
    logic step_last;
  } skf_sts_t;

endpackage

// ----- rtl/scalar_kalman_filter_core.sv -----
// Scalar Kalman filter over a stream of signed sensor samples.
//
// Input channel (in_*): one sample per transaction, a signed integer in
// in_tdata. Result channel (out_*): one signed Q16.16 estimate per sample.
// Configuration: write process noise (index 0) and measurement noise
// (index 1), both unsigned Q16.16, through cfg_we/cfg_addr/cfg_wdata while
// no sample is in flight.
//
// An accepted sample is prepared, then the restoring divider forms the
// gain (FRAC_BITS + 1 steps), then two shift-add multipliers run side by
// side (FRAC_BITS + 1 steps) before the estimate goes to the result
// register. A new sample is accepted once the previous one has left the
// datapath.
//
// Reset clears estimate, variance and both noise registers to zero and
// empties the result register. If the receiver stalls, the result holds
// in the output register while the next sample is processed; that sample
// then waits in the datapath until the output register frees up.
module scalar_kalman_filter_core import skf_pkg::*; #(
  parameter int FRAC_BITS    = 16,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // bits [SAMPLE_WIDTH-1:0]: measurement, rest zero padding
  input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] in_tdata,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // bits [31:0]: estimate
  output logic [EST_W-1:0]              out_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic                          cfg_we,
  input  logic [CFG_ADDR_W-1:0]         cfg_addr,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata
);

  skf_cmd_t                       cmd;
  skf_sts_t                       sts;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  // drop the byte padding, keep the sample's sign
  assign sample = signed'(in_tdata[SAMPLE_WIDTH-1:0]);

  skf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  skf_dp #(
    .FRAC_BITS    (FRAC_BITS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .sample    (sample),
    .cmd       (cmd),
    .sts       (sts),
    .est_out   (out_tdata)
  );

endmodule

// ----- rtl/skf_dp.sv -----
module skf_dp import skf_pkg::*; #(
  parameter int FRAC_BITS    = 16,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [CFG_ADDR_W-1:0]          cfg_addr,
  input  logic [CFG_DATA_W-1:0]          cfg_wdata,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  skf_cmd_t                       cmd,
  output skf_sts_t                       sts,
  output logic [EST_W-1:0]               est_out
);

  localparam int SQ_W   = SAMPLE_WIDTH + FRAC_BITS;
  localparam int DIFF_W = ((SQ_W > EST_W) ? SQ_W : EST_W) + 1;
  localparam int GAIN_W = FRAC_BITS + 1;
  localparam int PA_W   = DIFF_W + GAIN_W;
  localparam int PV_W   = VAR_W + GAIN_W;
  localparam int DEN_W  = VAR_W + 1;
  localparam int REM_W  = VAR_W + 2;
  localparam int CNT_W  = $clog2(FRAC_BITS + 1);
  localparam logic [GAIN_W-1:0] ONE_G = {1'b1, {FRAC_BITS{1'b0}}};

  logic [VAR_W-1:0]               pn_r, mn_r;
  logic signed [EST_W-1:0]        est_r;
  logic [VAR_W-1:0]               var_r;
  logic signed [SAMPLE_WIDTH-1:0] sample_r;
  logic [VAR_W-1:0]               prior_r;
  logic [DEN_W-1:0]               denom_r;
  logic [REM_W-1:0]               rem_r;
  logic [GAIN_W-1:0]              quo_r;
  logic signed [DIFF_W-1:0]       diff_r;
  logic [DIFF_W-1:0]              mag_r;
  logic                           neg_r;
  logic [GAIN_W-1:0]              g_r, ng_r;
  logic [PA_W-1:0]                acc_a_r;
  logic [PV_W-1:0]                acc_v_r;
  logic [CNT_W-1:0]               cnt_r;
  logic [EST_W-1:0]               out_r;

  logic [DEN_W-1:0]               prior_sum;
  logic [VAR_W-1:0]               prior_sat;
  logic signed [DIFF_W-1:0]       sample_q;
  logic                           rem_ge;
  logic [REM_W-1:0]               rem_sub;
  logic [GAIN_W-1:0]              gain;
  logic [DIFF_W-1:0]              corr;
  logic signed [DIFF_W:0]         corr_s;
  logic signed [DIFF_W:0]         est_wide;
  logic signed [EST_W-1:0]        est_sat;

  // prior variance, saturating at full scale
  assign prior_sum = {1'b0, var_r} + {1'b0, pn_r};
  assign prior_sat = prior_sum[DEN_W-1] ? '1 : prior_sum[VAR_W-1:0];

  assign sample_q = DIFF_W'(sample_r) <<< FRAC_BITS;

  // restoring division, one quotient bit per step
  assign rem_ge  = rem_r >= {1'b0, denom_r};
  assign rem_sub = rem_ge ? (rem_r - {1'b0, denom_r}) : rem_r;

  assign gain = (denom_r == '0) ? '0 : quo_r;

  // truncated correction and saturated estimate
  assign corr     = acc_a_r[FRAC_BITS +: DIFF_W];
  assign corr_s   = signed'({1'b0, corr});
  assign est_wide = (DIFF_W + 1)'(est_r) + (neg_r ? -corr_s : corr_s);

  always_comb begin
    if (est_wide > (DIFF_W + 1)'(EST_MAX_S)) begin
      est_sat = EST_MAX_S;
    end else if (est_wide < (DIFF_W + 1)'(EST_MIN_S)) begin
      est_sat = EST_MIN_S;
    end else begin
      est_sat = est_wide[EST_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pn_r  <= '0;
      mn_r  <= '0;
      est_r <= '0;
      var_r <= '0;
      cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_PROCESS_NOISE: pn_r <= cfg_wdata;
          REG_MEAS_NOISE:    mn_r <= cfg_wdata;
        endcase
      end
      if (cmd.prep || cmd.mul_init) begin
        cnt_r <= CNT_W'(FRAC_BITS);
      end else if (cmd.div_step || cmd.mul_step) begin
        cnt_r <= cnt_r - 1'b1;
      end
      if (cmd.finish) begin
        est_r <= est_sat;
        var_r <= acc_v_r[FRAC_BITS +: VAR_W];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample_r <= sample;
      prior_r  <= prior_sat;
    end
    if (cmd.prep) begin
      denom_r <= {1'b0, prior_r} + {1'b0, mn_r};
      rem_r   <= REM_W'(prior_r);
      quo_r   <= '0;
      diff_r  <= sample_q - DIFF_W'(est_r);
    end
    if (cmd.div_step) begin
      rem_r <= {rem_sub[REM_W-2:0], 1'b0};
      quo_r <= {quo_r[GAIN_W-2:0], rem_ge};
    end
    if (cmd.mul_init) begin
      g_r     <= gain;
      ng_r    <= ONE_G - gain;
      neg_r   <= diff_r[DIFF_W-1];
      mag_r   <= diff_r[DIFF_W-1] ? DIFF_W'(-diff_r) : DIFF_W'(diff_r);
      acc_a_r <= '0;
      acc_v_r <= '0;
    end
    if (cmd.mul_step) begin
      acc_a_r <= (acc_a_r << 1) + (g_r[GAIN_W-1] ? PA_W'(mag_r) : '0);
      acc_v_r <= (acc_v_r << 1) + (ng_r[GAIN_W-1] ? PV_W'(prior_r) : '0);
      g_r     <= g_r << 1;
      ng_r    <= ng_r << 1;
    end
    if (cmd.finish) begin
      out_r <= est_sat;
    end
  end

  assign sts.step_last = (cnt_r == '0);
  assign est_out       = out_r;

endmodule

// ----- rtl/skf_ctrl.sv -----
module skf_ctrl import skf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  input  skf_sts_t sts,
  output skf_cmd_t cmd
);

  skf_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_tvalid) state_nxt = ST_PREP;
      ST_PREP:     state_nxt = ST_DIV;
      ST_DIV:      if (sts.step_last) state_nxt = ST_MUL_INIT;
      ST_MUL_INIT: state_nxt = ST_MUL;
      ST_MUL:      if (sts.step_last) state_nxt = ST_FINISH;
      ST_FINISH:   if (slot_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      ST_PREP:     cmd.prep     = 1'b1;
      ST_DIV:      cmd.div_step = 1'b1;
      ST_MUL_INIT: cmd.mul_init = 1'b1;
      ST_MUL:      cmd.mul_step = 1'b1;
      ST_FINISH:   cmd.finish   = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  a_finish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("result not presented after finish");

  a_hold_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && out_valid_r && !out_tready) |=> state_r == ST_FINISH)
    else $error("finish left while output register full");

  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.prep, cmd.div_step, cmd.mul_init, cmd.mul_step, cmd.finish}))
    else $error("more than one datapath command");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> state_r == ST_PREP)
    else $error("accepted transaction did not start work");

endmodule
